// ===== hdl/slt_pkg.sv =====
// package: types and codes shared by the sorted list table
package slt_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DEDUP  = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    action_t                action;
    logic signed [31:0]     item_value;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic signed [31:0]     result_value;
    logic [CountWidth-1:0]  entry_count;
    logic                   last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN,
    S_SHIFT_REQ,
    S_SHIFT,
    S_INS_WRITE,
    S_DED_REQ,
    S_DED,
    S_LIST_REQ,
    S_LIST,
    S_EMIT
  } state_t;

endpackage

// ===== hdl/sorted_list_table_top.sv =====
// top level: sorted multiset of signed values held in one synchronous memory
//
// usage
// - input channel in_valid / in_stall carries an item: action and item_value
// - output channel out_valid / out_stall carries result items
// - one result per item, except list which gives one per held entry
//   (last_result marks the final one) or one empty status
// - the entries live in a single-port-write, one-read memory with a
//   registered read; every action walks it one entry per read
// - insert: scan from the top down shifting larger entries up by one,
//   then write the value into the freed slot and give the result
// - delete: scan for the match then shift the rest down
// - the memory read port sets the pace of every walk; one item at a time
// - reset clears the count and control state; memory contents need no clear
// - while out_stall is high the result register holds and the steps that
//   give a result wait; a new item is taken only once the previous one is fully done
module sorted_list_table_top
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NW = $clog2(CAPACITY + 1);

  // entry memory
  logic [ValueWidth-1:0] mem [CAPACITY];
  logic [ValueWidth-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [ValueWidth-1:0] wr_data;
  logic                  wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  logic [NW-1:0] count, count_next;
  logic [NW-1:0] idx, idx_next;       // walk index
  logic [NW-1:0] wptr, wptr_next;     // dedup and delete write pointer
  logic [ValueWidth-1:0] val, val_next;
  logic [ValueWidth-1:0] prev, prev_next;
  action_t act, act_next;
  out_item_t res, res_next;
  logic res_valid, res_valid_next;

  // signed compare of two patterns
  function automatic logic is_less(input logic [ValueWidth-1:0] a,
                                   input logic [ValueWidth-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [CountWidth-1:0] cnt5(input logic [NW-1:0] c);
    logic [NW+CountWidth-1:0] w;
    w = {{CountWidth{1'b0}}, c};
    return w[CountWidth-1:0];
  endfunction

  assign in_stall  = (state != S_IDLE) || (res_valid && out_stall);
  assign out_valid = res_valid;
  assign out_item  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
    idx  <= idx_next;
    wptr <= wptr_next;
    val  <= val_next;
    prev <= prev_next;
    act  <= act_next;
    res  <= res_next;
  end

  always_comb begin
    logic out_free;
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    wptr_next      = wptr;
    val_next       = val;
    prev_next      = prev;
    act_next       = act;
    res_next       = res;
    res_valid_next = res_valid;
    rd_addr        = idx[AW-1:0];
    wr_addr        = idx[AW-1:0];
    wr_data        = val;
    wr_en          = 1'b0;
    out_free       = !res_valid || !out_stall;
    if (res_valid && !out_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          act_next = in_item.action;
          val_next = in_item.item_value;
          case (in_item.action)
            ACT_INSERT: begin
              if (count >= NW'(CAPACITY)) begin
                res_next = '{ST_FULL, in_item.item_value, cnt5(count), 1'b1};
                res_valid_next = 1'b1;
              end else begin
                idx_next   = count;  // slot being filled, walk downward
                state_next = S_SHIFT_REQ;
              end
            end
            ACT_DELETE: begin
              idx_next   = '0;
              state_next = S_SCAN_REQ;
            end
            ACT_DEDUP: begin
              idx_next   = '0;
              wptr_next  = '0;
              state_next = S_DED_REQ;
            end
            ACT_LIST: begin
              if (count == '0) begin
                res_next = '{ST_EMPTY, in_item.item_value, cnt5(count), 1'b1};
                res_valid_next = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = S_LIST_REQ;
              end
            end
            default: ;
          endcase
        end
      end

      // insert: look at entry idx-1; move it up if larger than the value
      S_SHIFT_REQ: begin
        if (idx == '0) begin
          state_next = S_INS_WRITE;
        end else begin
          rd_addr    = AW'(idx - 1'b1);
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (is_less(val, rd_data)) begin
          wr_en      = 1'b1;
          wr_addr    = idx[AW-1:0];
          wr_data    = rd_data;
          idx_next   = idx - 1'b1;
          state_next = S_SHIFT_REQ;
        end else begin
          state_next = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_addr        = idx[AW-1:0];
          wr_data        = val;
          count_next     = count + 1'b1;
          res_next       = '{ST_OK, val, cnt5(count + 1'b1), 1'b1};
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      // delete: find first match, then pull later entries down
      S_SCAN_REQ: begin
        if (idx >= count) begin
          state_next = S_EMIT;
          res_next   = '{ST_NOT_FOUND, val, cnt5(count), 1'b1};
        end else begin
          rd_addr    = idx[AW-1:0];
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_data == val) begin
          state_next = S_DED_REQ; // reuse as shift-down request below
          wptr_next  = idx;
          idx_next   = idx + 1'b1;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_REQ;
        end
      end

      // dedup walk; for delete the same states move entries down
      S_DED_REQ: begin
        if (idx >= count) begin
          if (act == ACT_DELETE) begin
            count_next = count - 1'b1;
            res_next   = '{ST_OK, val, cnt5(count - 1'b1), 1'b1};
          end else begin
            count_next = wptr;
            res_next   = '{ST_OK, val, cnt5(wptr), 1'b1};
          end
          state_next = S_EMIT;
        end else begin
          rd_addr    = idx[AW-1:0];
          state_next = S_DED;
        end
      end
      S_DED: begin
        if (act == ACT_DELETE || wptr == '0 || rd_data != prev) begin
          wr_en     = 1'b1;
          wr_addr   = wptr[AW-1:0];
          wr_data   = rd_data;
          wptr_next = wptr + 1'b1;
        end
        prev_next  = rd_data;
        idx_next   = idx + 1'b1;
        state_next = S_DED_REQ;
      end

      // list: one read per entry, emit when the result register is free
      S_LIST_REQ: begin
        if (out_free) begin
          rd_addr    = idx[AW-1:0];
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        res_next       = '{ST_OK, rd_data, cnt5(count), (idx + 1'b1) == count};
        res_valid_next = 1'b1;
        idx_next       = idx + 1'b1;
        state_next     = ((idx + 1'b1) == count) ? S_IDLE : S_LIST_REQ;
      end

      S_EMIT: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== test/tb_sorted_list_table_top.sv =====
// testbench: sorted list table driven through named tests against a queue-based predictor
module tb_sorted_list_table_top;
  import slt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = 16;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  sorted_list_table_top #(.CAPACITY(Cap)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // clock: 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state: the table contents in ascending signed order
  logic signed [31:0] table_q[$];
  out_item_t          pending_q[$];
  int                 err_count = 0;
  int                 send_idle = 0;   // percent of cycles the sender idles
  int                 recv_idle = 0;   // percent of cycles the receiver stalls

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic out_item_t make_result(status_t st, logic signed [31:0] v, bit last);
    out_item_t r;
    r.status       = st;
    r.result_value = v;
    r.entry_count  = CountWidth'(table_q.size());
    r.last_result  = last;
    return r;
  endfunction

  // work out the expected results of one item and update the table copy
  task automatic predict_table_op(input in_item_t it);
    int pos;
    logic signed [31:0] uniq[$];
    case (it.action)
      ACT_INSERT: begin
        if (table_q.size() >= Cap) begin
          pending_q.push_back(make_result(ST_FULL, it.item_value, 1'b1));
        end else begin
          // insert after any equal entries
          pos = 0;
          while (pos < table_q.size() && !(it.item_value < table_q[pos])) pos++;
          table_q.insert(pos, it.item_value);
          pending_q.push_back(make_result(ST_OK, it.item_value, 1'b1));
        end
      end
      ACT_DELETE: begin
        pos = 0;
        while (pos < table_q.size() && table_q[pos] != it.item_value) pos++;
        if (pos >= table_q.size()) begin
          pending_q.push_back(make_result(ST_NOT_FOUND, it.item_value, 1'b1));
        end else begin
          table_q.delete(pos);
          pending_q.push_back(make_result(ST_OK, it.item_value, 1'b1));
        end
      end
      ACT_DEDUP: begin
        foreach (table_q[i])
          if (uniq.size() == 0 || uniq[$] != table_q[i]) uniq.push_back(table_q[i]);
        table_q = uniq;
        pending_q.push_back(make_result(ST_OK, it.item_value, 1'b1));
      end
      default: begin
        if (table_q.size() == 0) begin
          pending_q.push_back(make_result(ST_EMPTY, it.item_value, 1'b1));
        end else begin
          foreach (table_q[i])
            pending_q.push_back(make_result(ST_OK, table_q[i], i == table_q.size() - 1));
        end
      end
    endcase
  endtask

  // send one item, with random idle cycles ahead of it; valid stays up after
  // the accepting edge until the next call or the end of the run drives it
  task automatic send_item(input action_t act, input logic signed [31:0] v);
    in_item_t it;
    it.action     = act;
    it.item_value = v;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    predict_table_op(it);
  endtask

  // receiver: random stall, check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          automatic out_item_t exp_r = pending_q.pop_front();
          if (out_item.status !== exp_r.status)
            report_mismatch($sformatf("status %0d exp %0d", out_item.status, exp_r.status));
          if (out_item.result_value !== exp_r.result_value)
            report_mismatch($sformatf("value %0d exp %0d",
                                      out_item.result_value, exp_r.result_value));
          if (out_item.entry_count !== exp_r.entry_count)
            report_mismatch($sformatf("count %0d exp %0d",
                                      out_item.entry_count, exp_r.entry_count));
          if (out_item.last_result !== exp_r.last_result)
            report_mismatch($sformatf("last %0d exp %0d",
                                      out_item.last_result, exp_r.last_result));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // values drawn from a small pool so that duplicates and hits are common
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return $signed($urandom_range(12)) - 6;
    if (sel == 6) return 32'sh7fffffff;
    if (sel == 7) return 32'sh80000000;
    return $signed($urandom());
  endfunction

  task automatic test_directed();
    send_item(ACT_LIST, 32'sh12345678);     // list of an empty table
    send_item(ACT_DELETE, 32'sd5);          // delete with no match
    send_item(ACT_DEDUP, -32'sd1);          // dedup of an empty table
    send_item(ACT_INSERT, 32'sh7fffffff);
    send_item(ACT_INSERT, 32'sh80000000);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, 32'sd0);          // equal value goes after
    send_item(ACT_INSERT, -32'sd1);
    send_item(ACT_LIST, 32'sd0);
    send_item(ACT_DEDUP, 32'sh55555555);
    send_item(ACT_LIST, 32'shaaaaaaaa);
    send_item(ACT_DELETE, 32'sh80000000);
    send_item(ACT_DELETE, 32'sh7fffffff);
    // fill to capacity, then inserts into a full table
    for (int i = 0; i < Cap; i++) send_item(ACT_INSERT, $signed($urandom()));
    send_item(ACT_LIST, 32'sd0);
  endtask

  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45)      send_item(ACT_INSERT, pick_value());
      else if (r < 75) send_item(ACT_DELETE, pick_value());
      else if (r < 85) send_item(ACT_DEDUP, $signed($urandom()));
      else             send_item(ACT_LIST, $signed($urandom()));
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 37; recv_idle = 49;
    test_directed();
    test_random(100);
    send_idle = 49; recv_idle = 37;
    test_random(100);
    send_idle = 0; recv_idle = 0;
    test_random(110);
    in_valid <= 1'b0;
    // drain, then allow for the block's own latency
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8 * Cap) @(posedge clk);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("** sorted_list_table_top: PASSED **");
    end else begin
      $display("** sorted_list_table_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("** sorted_list_table_top: FAILED **");
    $finish;
  end
endmodule

// ===== sorted_list_table_top.f =====
hdl/slt_pkg.sv
hdl/sorted_list_table_top.sv
test/tb_sorted_list_table_top.sv
